>>> rtl/core/dstdoy_pkg.sv
package dstdoy_pkg;

  localparam int unsigned DAY_W   = 10;
  localparam int unsigned DNUM_W  = 9;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned IN_W    = 56;
  localparam int unsigned OUT_W   = 24;

  localparam logic [MONTH_W-1:0] DECEMBER = 4'd11;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd1;
  localparam logic [2:0]         LAST_WEEK = 3'd5;

  typedef enum logic [1:0] {
    KIND_MWD    = 2'd0,
    KIND_JULIAN = 2'd1,
    KIND_ZERO   = 2'd2
  } rule_kind_t;

  typedef logic signed [DAY_W-1:0] day_t;

  // first member sits in the top bits, so kind lands in the lowest bits
  typedef struct packed {
    logic [DNUM_W-1:0]  day_number;
    logic [2:0]         weekday;
    logic [2:0]         week;
    logic [MONTH_W-1:0] month;
    logic [1:0]         kind;
  } rule_t;

  typedef struct packed {
    logic [2:0] jan1;
    logic       leap;
  } year_info_t;

  typedef struct packed {
    day_t               day;
    logic               is_mwd;
    logic [MONTH_W-1:0] month;
  } lane_res_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  localparam logic [8:0] CUM_DAYS [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // 8 is 1 mod 7, so octal digits can be summed
  function automatic logic [2:0] mod7(input logic [8:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

>>> rtl/core/dstdoy_year.sv
module dstdoy_year (
  input  logic                   clk,
  input  logic                   en,
  input  logic [7:0]             year_since_1900,
  output dstdoy_pkg::year_info_t info
);

  logic [6:0] leaps;
  logic [8:0] days;

  // leap days in 1900 .. year-1; 1900 and 2100 are not leap years
  always_comb begin
    leaps = 7'(({1'b0, year_since_1900} + 9'd3) >> 2)
          - 7'(year_since_1900 >= 8'd1)
          - 7'(year_since_1900 >= 8'd201);
    // 365 is 1 mod 7 and 1900-01-01 was a monday
    days = 9'd1 + 9'(year_since_1900) + 9'(leaps);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info.jan1 <= dstdoy_pkg::mod7(days);
      info.leap <= (year_since_1900[1:0] == 2'd0) && (year_since_1900 != 8'd0)
                && (year_since_1900 != 8'd200);
    end
  end

endmodule

>>> rtl/core/dstdoy_lane.sv
module dstdoy_lane (
  input  logic                   clk,
  input  dstdoy_pkg::stage_en_t  en,
  input  dstdoy_pkg::rule_t      rule,
  input  dstdoy_pkg::year_info_t year,
  output dstdoy_pkg::lane_res_t  res
);

  // stage 1: clamp month, fold weekday
  logic [1:0]                      s1_kind;
  logic [dstdoy_pkg::MONTH_W-1:0]  s1_month;
  logic [2:0]                      s1_week;
  logic [2:0]                      s1_wday;
  logic [dstdoy_pkg::DNUM_W-1:0]   s1_dnum;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_kind  <= rule.kind;
      s1_month <= (rule.month > dstdoy_pkg::DECEMBER) ? dstdoy_pkg::DECEMBER : rule.month;
      s1_week  <= rule.week;
      s1_wday  <= (rule.weekday == 3'd7) ? 3'd0 : rule.weekday;
      s1_dnum  <= rule.day_number;
    end
  end

  // stage 2: first of month
  logic [8:0] yday;
  logic [4:0] dim;
  logic [8:0] wd_sum;

  always_comb begin
    yday   = dstdoy_pkg::CUM_DAYS[s1_month] + 9'(year.leap && (s1_month >= 4'd2));
    dim    = dstdoy_pkg::MONTH_LEN[s1_month]
           + 5'(year.leap && (s1_month == dstdoy_pkg::FEBRUARY));
    wd_sum = 9'(year.jan1) + yday;
  end

  logic [1:0]                      s2_kind;
  logic [dstdoy_pkg::MONTH_W-1:0]  s2_month;
  logic [2:0]                      s2_week;
  logic [2:0]                      s2_wday;
  logic [dstdoy_pkg::DNUM_W-1:0]   s2_dnum;
  logic [8:0]                      s2_yday;
  logic [4:0]                      s2_dim;
  logic [2:0]                      s2_first_wd;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_kind     <= s1_kind;
      s2_month    <= s1_month;
      s2_week     <= s1_week;
      s2_wday     <= s1_wday;
      s2_dnum     <= s1_dnum;
      s2_yday     <= yday;
      s2_dim      <= dim;
      s2_first_wd <= dstdoy_pkg::mod7(wd_sum);
    end
  end

  // stage 3: weekday offset and week step
  logic [2:0]             off;
  logic                   last_fits;
  logic signed [4:0]      wk;
  dstdoy_pkg::day_t       wk7;
  dstdoy_pkg::day_t       day_calc;

  always_comb begin
    off = (s2_wday >= s2_first_wd) ? 3'(s2_wday - s2_first_wd)
                                   : 3'(s2_wday + 3'd7 - s2_first_wd);
    last_fits = (6'(off) + 6'd29) <= 6'(s2_dim);
    if (s2_week == dstdoy_pkg::LAST_WEEK) begin
      wk = last_fits ? 5'sd4 : 5'sd3;
    end else begin
      wk = $signed({2'b00, s2_week}) - 5'sd1;
    end
    wk7 = (dstdoy_pkg::day_t'(wk) <<< 3) - dstdoy_pkg::day_t'(wk);
    case (s2_kind)
      dstdoy_pkg::KIND_MWD: begin
        day_calc = dstdoy_pkg::day_t'({1'b0, off}) + dstdoy_pkg::day_t'({1'b0, s2_yday}) + wk7;
      end
      dstdoy_pkg::KIND_JULIAN: begin
        day_calc = dstdoy_pkg::day_t'({1'b0, s2_dnum}) - dstdoy_pkg::day_t'(1);
      end
      default: begin
        day_calc = dstdoy_pkg::day_t'({1'b0, s2_dnum});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      res.day    <= day_calc;
      res.is_mwd <= (s2_kind == dstdoy_pkg::KIND_MWD);
      res.month  <= s2_month;
    end
  end

endmodule

>>> rtl/core/dstdoy_merge.sv
module dstdoy_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  dstdoy_pkg::lane_res_t               end_res,
  input  dstdoy_pkg::lane_res_t               start_res,
  output logic                                take,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dstdoy_pkg::OUT_W-1:0]        m_tdata
);

  logic after;

  always_comb begin
    take = !m_tvalid || m_tready;
    // both month rules in different months: month order decides
    if (end_res.is_mwd && start_res.is_mwd && (end_res.month != start_res.month)) begin
      after = end_res.month > start_res.month;
    end else begin
      after = end_res.day > start_res.day;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {5'b0, after, start_res.day[8:0], end_res.day[8:0]};
    end
  end

endmodule

>>> rtl/core/dst_rule_day_of_year.sv
// Day of year of a pair of POSIX TZ daylight rules (end and start) for one
// Gregorian year 1900..2155, with a flag for the end transition lying after
// the start. One request is taken every clock cycle while s_tready is high:
// a shared year stage and two identical rule lanes run three register
// stages, and the merge stage compares the two days and holds the output
// register. Each stage moves up whenever the one after it is empty or
// advancing, so a stalled output only blocks new requests once all four
// stages are full.
module dst_rule_day_of_year (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // year_since_1900[7:0], end_rule_kind[9:8], end_month[13:10], end_week[16:14],
  // end_weekday[19:17], end_day_number[28:20], start_rule_kind[30:29],
  // start_month[34:31], start_week[37:35], start_weekday[40:38],
  // start_day_number[49:41], zero fill [55:50]
  input  logic [dstdoy_pkg::IN_W-1:0]         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // end_day_of_year[8:0], start_day_of_year[17:9], end_after_start[18],
  // zero fill [23:19]
  output logic [dstdoy_pkg::OUT_W-1:0]        m_tdata
);

  dstdoy_pkg::stage_en_t  en;
  dstdoy_pkg::year_info_t year_info;
  dstdoy_pkg::rule_t      end_rule;
  dstdoy_pkg::rule_t      start_rule;
  dstdoy_pkg::lane_res_t  end_res;
  dstdoy_pkg::lane_res_t  start_res;
  logic                   take;
  logic                   v1;
  logic                   v2;
  logic                   v3;

  assign end_rule   = dstdoy_pkg::rule_t'(s_tdata[28:8]);
  assign start_rule = dstdoy_pkg::rule_t'(s_tdata[49:29]);

  always_comb begin
    en.s3    = !v3 || take;
    en.s2    = !v2 || en.s3;
    en.s1    = !v1 || en.s2;
    s_tready = en.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= s_tvalid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
    end
  end

  dstdoy_year u_year (
    .clk             (clk),
    .en              (en.s1),
    .year_since_1900 (s_tdata[7:0]),
    .info            (year_info)
  );

  dstdoy_lane u_end_lane (
    .clk  (clk),
    .en   (en),
    .rule (end_rule),
    .year (year_info),
    .res  (end_res)
  );

  dstdoy_lane u_start_lane (
    .clk  (clk),
    .en   (en),
    .rule (start_rule),
    .year (year_info),
    .res  (start_res)
  );

  dstdoy_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .end_res   (end_res),
    .start_res (start_res),
    .take      (take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
